/* hdl/blecsa2_pkg.sv */
// Shared types, constants and a helper function for the BLE CSA#2 channel selector.
`timescale 1ns / 1ps

package blecsa2_pkg;

   localparam int unsigned NumChannels  = 37;
   localparam int unsigned ChanWidth    = 6;
   localparam int unsigned PrnWidth     = 16;
   localparam int unsigned CountWidth   = 6;
   localparam int unsigned GroupSize    = 8;
   localparam int unsigned NumGroups    = (NumChannels + GroupSize - 1) / GroupSize;
   localparam int unsigned GroupCntWidth = 4;
   localparam int unsigned QuotWidth    = 11;
   localparam int unsigned RecipWidth   = 17;
   localparam int unsigned RecipShift   = 22;
   localparam int unsigned CsrDataWidth = 64;
   localparam int unsigned CsrAddrWidth = 5;

   // floor(2^22 / 37) + 1: exact quotient for every 16-bit dividend
   localparam logic [RecipWidth-1:0] RecipMul37 = 17'd113360;
   localparam logic [CountWidth-1:0] ResetUsedCount = 6'd37;

   typedef enum logic [1:0] {
      RegChanId    = 2'd0,
      RegChanMap   = 2'd1,
      RegUsedCount = 2'd2
   } reg_index_type;

   typedef logic [PrnWidth-1:0]                        prn_type;
   typedef logic [NumChannels-1:0]                     usable_map_type;
   typedef logic [NumChannels-1:0][ChanWidth-1:0]      rank_vec_type;

   typedef struct packed {
      prn_type                 chan_id;
      usable_map_type          usable_map;
      logic [CountWidth-1:0]   used_count;
      rank_vec_type            rank;
   } cfg_type;

   // One scrambling round: reverse bits within each byte, then 17*x + id mod 2^16.
   function automatic prn_type prn_round(prn_type x, prn_type id);
      prn_type r;
      for (int i = 0; i < 8; i++) begin
         r[7 - i]  = x[i];
         r[15 - i] = x[8 + i];
      end
      return r + (r << 4) + id;
   endfunction

endpackage

/* hdl/ble_channel_selection_csa2.sv */
// BLE channel selection algorithm #2: event counter in, data channel index out.
//
// One event counter word enters per cycle when the output side keeps up, and its
// channel word leaves from the last stage; both sides use valid/ready, and every
// stage carries its own valid bit, so a stall on the output holds words in place
// and bubbles are squeezed out as the pipe refills. Stages one to three run the
// three scrambling rounds (byte-wise bit reversal, 17*x + id) and the final XOR
// that give prn_e; stage four forms the mod-37 quotient by a reciprocal multiply
// and the remap index used_channel_count*prn_e >> 16; stage five recovers the
// unmapped channel, tests its map bit and matches the remap index against a
// per-channel rank table; stage six selects and registers the result. The rank
// table (number of set map bits below each channel) is rebuilt from the map in
// three registered steps, so it is current once they have run after a channel
// map write; write configuration only while no word is in flight. A remap index
// with no matching set bit gives channel 0 with map_error raised.
`timescale 1ns / 1ps

module ble_channel_selection_csa2 (
   input  logic                                    clock,
   input  logic                                    reset,
   // event counter words
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [15:0]                             req_event_counter,
   // channel words
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [5:0]                              rsp_channel_index,
   output logic                                    rsp_was_remapped,
   output logic                                    rsp_map_error,
   // register port
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [blecsa2_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [blecsa2_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [blecsa2_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                    csr_pready
);
   import blecsa2_pkg::*;

   cfg_type cfg;
   logic    prn_valid;
   logic    prn_ready;
   prn_type prn;

   // registers: identifier at 0x00, map at 0x08, used count at 0x10
   blecsa2_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // scramble the counter into prn_e
   blecsa2_prn u_prn (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .event_counter (req_event_counter),
      .chan_id       (cfg.chan_id),
      .out_valid     (prn_valid),
      .out_ready     (prn_ready),
      .prn           (prn)
   );

   // reduce prn_e to a channel, remapping onto the used channels when needed
   blecsa2_map u_map (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (prn_valid),
      .in_ready      (prn_ready),
      .prn           (prn),
      .cfg           (cfg),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .channel_index (rsp_channel_index),
      .was_remapped  (rsp_was_remapped),
      .map_error     (rsp_map_error)
   );

endmodule

/* hdl/blecsa2_csr.sv */
// Configuration registers and the per-channel rank table derived from the map.
`timescale 1ns / 1ps

module blecsa2_csr (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [blecsa2_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [blecsa2_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [blecsa2_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                    csr_pready,
   output blecsa2_pkg::cfg_type                    cfg
);
   import blecsa2_pkg::*;

   prn_type                  chan_id_ff;
   usable_map_type           usable_map_ff;
   logic [CountWidth-1:0]    used_count_ff;
   logic                     wr_en;
   reg_index_type            reg_sel;

   logic [GroupCntWidth-1:0] group_cnt_ff [NumGroups];
   logic [GroupCntWidth-1:0] group_cnt_in [NumGroups];
   logic [ChanWidth-1:0]     base_ff [NumGroups];
   logic [ChanWidth-1:0]     base_in [NumGroups];
   rank_vec_type             rank_ff;
   rank_vec_type             rank_in;

   assign csr_pready = 1'b1;
   assign reg_sel    = reg_index_type'(csr_paddr[4:3]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_id_ff    <= '0;
         usable_map_ff <= '1;
         used_count_ff <= ResetUsedCount;
      end else if (wr_en) begin
         case (reg_sel)
            RegChanId:    chan_id_ff    <= csr_pwdata[PrnWidth-1:0];
            RegChanMap:   usable_map_ff <= csr_pwdata[NumChannels-1:0];
            RegUsedCount: used_count_ff <= csr_pwdata[CountWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         RegChanId:    csr_prdata = CsrDataWidth'(chan_id_ff);
         RegChanMap:   csr_prdata = CsrDataWidth'(usable_map_ff);
         RegUsedCount: csr_prdata = CsrDataWidth'(used_count_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // Rank table in three registered steps: byte counts, byte bases, ranks.
   always_comb begin
      for (int g = 0; g < NumGroups; g++) begin
         group_cnt_in[g] = '0;
         for (int b = 0; b < GroupSize; b++) begin
            if (g * GroupSize + b < NumChannels) begin
               group_cnt_in[g] = group_cnt_in[g]
                               + GroupCntWidth'(usable_map_ff[g * GroupSize + b]);
            end
         end
      end
   end

   always_comb begin
      base_in[0] = '0;
      for (int g = 1; g < NumGroups; g++) begin
         base_in[g] = base_in[g - 1] + ChanWidth'(group_cnt_ff[g - 1]);
      end
   end

   always_comb begin
      for (int ch = 0; ch < NumChannels; ch++) begin
         rank_in[ch] = base_ff[ch / GroupSize];
         for (int b = (ch / GroupSize) * GroupSize; b < ch; b++) begin
            rank_in[ch] = rank_in[ch] + ChanWidth'(usable_map_ff[b]);
         end
      end
   end

   always_ff @(posedge clock) begin
      group_cnt_ff <= group_cnt_in;
      base_ff      <= base_in;
      rank_ff      <= rank_in;
   end

   assign cfg.chan_id    = chan_id_ff;
   assign cfg.usable_map = usable_map_ff;
   assign cfg.used_count = used_count_ff;
   assign cfg.rank       = rank_ff;

endmodule

/* hdl/blecsa2_prn.sv */
// Three-stage pipeline that scrambles the event counter into prn_e.
`timescale 1ns / 1ps

module blecsa2_prn (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  blecsa2_pkg::prn_type  event_counter,
   input  blecsa2_pkg::prn_type  chan_id,
   output logic                  out_valid,
   input  logic                  out_ready,
   output blecsa2_pkg::prn_type  prn
);
   import blecsa2_pkg::*;

   logic    v1_ff, v2_ff, v3_ff;
   logic    rdy1, rdy2, rdy3;
   prn_type x1_ff, x2_ff, x3_ff;
   prn_type x1_in, x2_in, x3_in;

   // A stage takes a new word when empty or when its successor takes its word.
   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   assign x1_in = prn_round(event_counter ^ chan_id, chan_id);
   assign x2_in = prn_round(x1_ff, chan_id);
   assign x3_in = prn_round(x2_ff, chan_id) ^ chan_id;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) x1_ff <= x1_in;
      if (rdy2 && v1_ff)    x2_ff <= x2_in;
      if (rdy3 && v2_ff)    x3_ff <= x3_in;
   end

   assign out_valid = v3_ff;
   assign prn       = x3_ff;

endmodule

/* hdl/blecsa2_map.sv */
// Three-stage pipeline: mod-37 quotient and remap index, remainder with map test and rank match, result.
`timescale 1ns / 1ps

module blecsa2_map (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  blecsa2_pkg::prn_type                 prn,
   input  blecsa2_pkg::cfg_type                 cfg,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic [blecsa2_pkg::ChanWidth-1:0]    channel_index,
   output logic                                 was_remapped,
   output logic                                 map_error
);
   import blecsa2_pkg::*;

   logic                        v4_ff, v5_ff, v6_ff;
   logic                        rdy4, rdy5, rdy6;

   // stage 4
   logic [PrnWidth+RecipWidth-1:0]  quot_prod;
   logic [PrnWidth+CountWidth-1:0]  remap_prod;
   logic [QuotWidth-1:0]            quot_ff;
   prn_type                         prn4_ff;
   logic [ChanWidth-1:0]            remap_ff;

   // stage 5
   prn_type                         quot37;
   prn_type                         rem_wide;
   logic [ChanWidth-1:0]            rem_in;
   usable_map_type                  match_in;
   logic [ChanWidth-1:0]            rem5_ff;
   logic                            hit5_ff;
   usable_map_type                  match5_ff;

   // stage 6
   logic [ChanWidth-1:0]            chan_enc;
   logic                            found;
   logic [ChanWidth-1:0]            channel_index_ff;
   logic                            was_remapped_ff;
   logic                            map_error_ff;

   assign rdy6     = !v6_ff || out_ready;
   assign rdy5     = !v5_ff || rdy6;
   assign rdy4     = !v4_ff || rdy5;
   assign in_ready = rdy4;

   assign quot_prod  = (PrnWidth + RecipWidth)'(prn) * (PrnWidth + RecipWidth)'(RecipMul37);
   assign remap_prod = (PrnWidth + CountWidth)'(cfg.used_count)
                     * (PrnWidth + CountWidth)'(prn);

   // remainder: prn - 37*q, with 37*q as shifts and adds
   assign quot37   = (PrnWidth'(quot_ff) << 5) + (PrnWidth'(quot_ff) << 2)
                   + PrnWidth'(quot_ff);
   assign rem_wide = prn4_ff - quot37;
   assign rem_in   = rem_wide[ChanWidth-1:0];

   always_comb begin
      for (int ch = 0; ch < NumChannels; ch++) begin
         match_in[ch] = cfg.usable_map[ch] && (cfg.rank[ch] == remap_ff);
      end
   end

   // at most one channel matches, so an OR of the indices encodes it
   always_comb begin
      chan_enc = '0;
      for (int ch = 0; ch < NumChannels; ch++) begin
         if (match5_ff[ch]) chan_enc = chan_enc | ChanWidth'(ch);
      end
   end
   assign found = |match5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (rdy4) v4_ff <= in_valid;
         if (rdy5) v5_ff <= v4_ff;
         if (rdy6) v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4 && in_valid) begin
         quot_ff  <= quot_prod[RecipShift+QuotWidth-1:RecipShift];
         prn4_ff  <= prn;
         remap_ff <= remap_prod[PrnWidth+CountWidth-1:PrnWidth];
      end
      if (rdy5 && v4_ff) begin
         rem5_ff   <= rem_in;
         hit5_ff   <= cfg.usable_map[rem_in];
         match5_ff <= match_in;
      end
      if (rdy6 && v5_ff) begin
         channel_index_ff <= hit5_ff ? rem5_ff : (found ? chan_enc : '0);
         was_remapped_ff  <= !hit5_ff;
         map_error_ff     <= !hit5_ff && !found;
      end
   end

   assign out_valid     = v6_ff;
   assign channel_index = channel_index_ff;
   assign was_remapped  = was_remapped_ff;
   assign map_error     = map_error_ff;

endmodule
